// ===== hdl/sphere_spot_burial_area_defines.svh =====
`ifndef SPHERE_SPOT_BURIAL_AREA_DEFINES_SVH
`define SPHERE_SPOT_BURIAL_AREA_DEFINES_SVH

// Same-cycle implication on the block clock, held off while reset is low.
`define SSBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssba: check failed");

// Next-cycle implication on the block clock, held off while reset is low.
`define SSBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssba: check failed");

`endif

// ===== hdl/ssba_pkg.sv =====
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared types, codes and constants of the sphere spot burial area block.
// ----------------------------------------------------------------------------
package ssba_pkg;

    // Default sizing of the block.
    localparam int MAX_SPOTS_DEF  = 1024;
    localparam int COORD_BITS_DEF = 20;

    // Fixed field widths.
    localparam int OP_W          = 2;
    localparam int INDEX_W       = 10;
    localparam int RADIUS_W      = 16;
    localparam int SPOT_COUNT_W  = 11;
    localparam int COUNT_W       = 11;
    localparam int AREA_W        = 28;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [SPOT_COUNT_W-1:0] SPOT_COUNT_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0]      COUNT_MAX        = 11'h7FF;
    localparam logic [AREA_W-1:0]       AREA_MAX         = 28'hFFFFFFF;

    // Four pi in unsigned Q24, rounded to nearest.
    localparam logic [AREA_W-1:0]       FOUR_PI_Q24      = 28'd210828714;

    // Largest coordinate difference that passes the far check.
    localparam int MAG_LIMIT = 65535;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_TEST      = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_REPORT    = 2'd3
    } op_t;

    // Configuration register select (address bit 2).
    typedef enum logic {
        REG_OWN_RADIUS = 1'b0,
        REG_SPOT_COUNT = 1'b1
    } reg_sel_t;

    // Coordinate axis handled by the shared unit in one step.
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Control from the sequencer to the shared spot unit.
    typedef struct packed {
        logic  start;
        logic  step;
        logic  subtract;
        axis_t axis;
    } unit_ctrl_t;

    // Main sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_PREP,
        ST_AXIS_X,
        ST_AXIS_Y,
        ST_AXIS_Z,
        ST_WRITE,
        ST_AREA,
        ST_WAIT
    } top_state_t;

    // Area unit states.
    typedef enum logic [2:0] {
        AR_IDLE,
        AR_SQUARE,
        AR_SCALE,
        AR_ROUND,
        AR_PRODUCT,
        AR_DIVIDE,
        AR_DONE
    } area_state_t;

endpackage

// ===== hdl/ssba_if.sv =====
// ----------------------------------------------------------------------------
// ssba_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------

// Operation item channel.
interface ssba_req_if
    import ssba_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              operation;
    logic [INDEX_W-1:0]           spot_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [RADIUS_W-1:0]          other_radius;

    modport source (
        output valid, operation, spot_index, pos_x, pos_y, pos_z, other_radius,
        input  ready
    );
    modport sink (
        input  valid, operation, spot_index, pos_x, pos_y, pos_z, other_radius,
        output ready
    );
endinterface

// Result item channel.
interface ssba_rsp_if
    import ssba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [COUNT_W-1:0] buried_count;
    logic [AREA_W-1:0]  total_area;
    logic [AREA_W-1:0]  buried_area;

    modport source (
        output valid, buried_count, total_area, buried_area,
        input  ready
    );
    modport sink (
        input  valid, buried_count, total_area, buried_area,
        output ready
    );
endinterface

// ===== hdl/ssba_spot_mem.sv =====
// ----------------------------------------------------------------------------
// ssba_spot_mem
// Spot store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ssba_spot_mem
    import ssba_pkg::*;
#(
    parameter int DEPTH = MAX_SPOTS_DEF,
    parameter int WIDTH = 3 * COORD_BITS_DEF + 1
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] spot_ram [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            spot_ram[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= spot_ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ssba_spot_unit.sv =====
// ----------------------------------------------------------------------------
// ssba_spot_unit
// Shared coordinate unit: one adder, one squarer and an accumulator, used
// once per axis for the neighbor distance test or the saturating shift.
// ----------------------------------------------------------------------------
module ssba_spot_unit
    import ssba_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  unit_ctrl_t                   ctrl,
    input  logic [RADIUS_W-1:0]          radius,
    input  logic [3*COORD_BITS:0]        spot_word,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    output logic                         near,
    output logic [3*COORD_BITS-1:0]      new_coords
);

    localparam int SUM_W = COORD_BITS + 1;
    localparam int EXT_W = (SUM_W > RADIUS_W + 1) ? SUM_W : RADIUS_W + 1;
    localparam int SQ_W  = 2 * RADIUS_W;
    localparam int ACC_W = SQ_W + 2;

    localparam logic signed [COORD_BITS-1:0] COORD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] spot_c;
    logic signed [COORD_BITS-1:0] ref_c;
    logic signed [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]             mag;
    logic [EXT_W-1:0]             mag_ext;
    logic                         far_now;
    logic [RADIUS_W-1:0]          sq_in;
    logic [SQ_W-1:0]              sq;
    logic signed [COORD_BITS-1:0] sat_c;

    logic [ACC_W-1:0]             acc_reg;
    logic                         far_reg;
    logic [SQ_W-1:0]              r2_reg;
    logic signed [COORD_BITS-1:0] new_x_reg;
    logic signed [COORD_BITS-1:0] new_y_reg;
    logic signed [COORD_BITS-1:0] new_z_reg;

    // Pick the coordinate pair for this axis.
    always_comb
    begin
        unique case (ctrl.axis)
            AXIS_X:
            begin
                spot_c = spot_word[COORD_BITS:1];
                ref_c  = pos_x;
            end
            AXIS_Y:
            begin
                spot_c = spot_word[2*COORD_BITS:COORD_BITS+1];
                ref_c  = pos_y;
            end
            default:
            begin
                spot_c = spot_word[3*COORD_BITS:2*COORD_BITS+1];
                ref_c  = pos_z;
            end
        endcase
    end

    // Difference for the test, sum for the shift.
    assign sum = ctrl.subtract ? (SUM_W'(spot_c) - SUM_W'(ref_c))
                               : (SUM_W'(spot_c) + SUM_W'(ref_c));

    // Magnitude and the far check.
    assign mag     = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    assign mag_ext = EXT_W'(mag);
    assign far_now = mag_ext > EXT_W'(MAG_LIMIT);

    // The squarer serves the radius at start and the axis difference after.
    assign sq_in = ctrl.start ? radius : mag_ext[RADIUS_W-1:0];
    assign sq    = SQ_W'(sq_in) * SQ_W'(sq_in);

    // Saturate the shifted coordinate to the signed range.
    always_comb
    begin
        if (sum[SUM_W-1] != sum[SUM_W-2])
        begin
            sat_c = sum[SUM_W-1] ? COORD_LO : COORD_HI;
        end
        else
        begin
            sat_c = sum[COORD_BITS-1:0];
        end
    end

    // Accumulator, far flag and radius square.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            r2_reg <= sq;
        end
        else if (ctrl.step)
        begin
            if (ctrl.axis == AXIS_X)
            begin
                acc_reg <= ACC_W'(sq);
                far_reg <= far_now;
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(sq);
                far_reg <= far_reg | far_now;
            end
        end
    end

    // Shifted coordinates, one axis per step.
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            case (ctrl.axis)
                AXIS_X:  new_x_reg <= sat_c;
                AXIS_Y:  new_y_reg <= sat_c;
                default: new_z_reg <= sat_c;
            endcase
        end
    end

    assign near       = !far_reg && (acc_reg < ACC_W'(r2_reg));
    assign new_coords = {new_z_reg, new_y_reg, new_x_reg};

endmodule

// ===== hdl/ssba_area_unit.sv =====
// ----------------------------------------------------------------------------
// ssba_area_unit
// Area unit: one shared multiplier for the radius square, the 4 pi scale
// and the count product, then a restoring divider by the live spot count.
// ----------------------------------------------------------------------------
module ssba_area_unit
    import ssba_pkg::*;
#(
    parameter int MAX_SPOTS = MAX_SPOTS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             ack,
    input  logic [RADIUS_W-1:0]              own_radius,
    input  logic [$clog2(MAX_SPOTS+1)-1:0]   count,
    input  logic [$clog2(MAX_SPOTS+1)-1:0]   live,
    output logic                             done,
    output logic [AREA_W-1:0]                total_area,
    output logic [AREA_W-1:0]                buried_area
);

    localparam int CNT_W  = $clog2(MAX_SPOTS + 1);
    localparam int DIV_W  = CNT_W + AREA_W;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    area_state_t state_reg;
    area_state_t state_next;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-1:0]   rounded;
    logic [MUL_W-1:0]    round_hi;
    logic [CNT_W:0]      trial;
    logic                q_bit;
    logic [CNT_W-1:0]    rem_next;

    logic [PROD_W-1:0]   prod_reg;
    logic [AREA_W-1:0]   total_reg;
    logic [DIV_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    live_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AR_IDLE:    if (start) state_next = AR_SQUARE;
            AR_SQUARE:  state_next = AR_SCALE;
            AR_SCALE:   state_next = AR_ROUND;
            AR_ROUND:   state_next = AR_PRODUCT;
            AR_PRODUCT: state_next = AR_DIVIDE;
            AR_DIVIDE:
            begin
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = AR_DONE;
                end
            end
            AR_DONE:    if (ack) state_next = AR_IDLE;
            default:    state_next = AR_IDLE;
        endcase
    end

    // Multiplier operand select and done flag.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        done  = 1'b0;
        unique case (state_reg)
            AR_SQUARE:
            begin
                mul_a = MUL_W'(radius_reg);
                mul_b = MUL_W'(radius_reg);
            end
            AR_SCALE:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(FOUR_PI_Q24);
            end
            AR_PRODUCT:
            begin
                mul_a = MUL_W'(count_reg);
                mul_b = MUL_W'(total_reg);
            end
            AR_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Round to nearest and keep the integer part.
    assign rounded  = prod_reg + (PROD_W'(1) << (MUL_W - 1));
    assign round_hi = rounded[PROD_W-1:MUL_W];

    // One restoring division step.
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign q_bit    = trial >= {1'b0, live_reg};
    assign rem_next = q_bit ? CNT_W'(trial - {1'b0, live_reg}) : trial[CNT_W-1:0];

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            AR_IDLE:
            begin
                if (start)
                begin
                    radius_reg <= own_radius;
                    count_reg  <= count;
                    live_reg   <= live;
                end
            end
            AR_SQUARE, AR_SCALE:
            begin
                prod_reg <= product;
            end
            AR_ROUND:
            begin
                total_reg <= (round_hi > MUL_W'(AREA_MAX)) ? AREA_MAX
                                                           : round_hi[AREA_W-1:0];
            end
            AR_PRODUCT:
            begin
                quo_reg  <= product[DIV_W-1:0];
                rem_reg  <= '0;
                step_reg <= '0;
            end
            AR_DIVIDE:
            begin
                rem_reg  <= rem_next;
                quo_reg  <= {quo_reg[DIV_W-2:0], q_bit};
                step_reg <= step_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Buried area never exceeds the total.
    assign total_area  = total_reg;
    assign buried_area = (quo_reg > DIV_W'(total_reg)) ? total_reg : quo_reg[AREA_W-1:0];

endmodule

// ===== hdl/sphere_spot_burial_area.sv =====
// Sphere spot burial area: keeps up to MAX_SPOTS surface spots of one sphere
// with a sticky buried flag each, and returns one result (buried count, total
// area 4*pi*r^2 and buried area) for every operation item. One item is in
// work at a time. A load with an index in range reads and writes its spot,
// a neighbor test walks the n live spots and a translate all MAX_SPOTS spots
// (n is the live spot count); these and a report then run the area pass and
// load the output register. The spot walk handles the three axes of a spot
// in turn through one adder and squarer, then writes the spot back, as the
// spot memory has one write port. After reset a clearing pass over all
// MAX_SPOTS entries zeroes the flags before the first item is accepted;
// configuration writes are taken throughout.
`include "sphere_spot_burial_area_defines.svh"

// ----------------------------------------------------------------------------
// sphere_spot_burial_area
// Top level: configuration port, item sequencer, spot store and result stage.
// ----------------------------------------------------------------------------
module sphere_spot_burial_area
    import ssba_pkg::*;
#(
    parameter int MAX_SPOTS  = MAX_SPOTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    ssba_req_if.sink           req,
    ssba_rsp_if.source         rsp
);

    localparam int IDX_W  = $clog2(MAX_SPOTS);
    localparam int CNT_W  = $clog2(MAX_SPOTS + 1);
    localparam int WORD_W = 3 * COORD_BITS + 1;
    localparam int CMP_W  = (CNT_W > SPOT_COUNT_W) ? CNT_W : SPOT_COUNT_W;
    localparam int IDXC_W = (IDX_W + 1 > INDEX_W) ? IDX_W + 1 : INDEX_W;

    // Configuration registers.
    logic [RADIUS_W-1:0]     own_radius_reg;
    logic [SPOT_COUNT_W-1:0] spot_count_reg;
    logic                    cfg_write;
    reg_sel_t                reg_sel;

    // Sequencer and item registers.
    top_state_t                   state_reg;
    top_state_t                   state_next;
    op_t                          op_reg;
    logic [IDXC_W-1:0]            idx_reg;
    logic signed [COORD_BITS-1:0] pos_x_reg;
    logic signed [COORD_BITS-1:0] pos_y_reg;
    logic signed [COORD_BITS-1:0] pos_z_reg;
    logic [RADIUS_W-1:0]          radius_reg;
    logic [CNT_W-1:0]             k_reg;
    logic [CNT_W-1:0]             k_next;
    logic [CNT_W-1:0]             limit_reg;
    logic [CNT_W-1:0]             live_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             live;
    logic [CMP_W-1:0]             sc_ext;
    logic [IDXC_W-1:0]            req_idx;
    logic                         req_idx_ok;
    logic                         accept;
    logic                         last;

    // Memory and unit control.
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [WORD_W-1:0] mem_rd_data;
    unit_ctrl_t        unit_ctrl;
    logic              unit_near;
    logic [3*COORD_BITS-1:0] unit_coords;
    logic              area_start;
    logic              area_ack;
    logic              area_done;
    logic [AREA_W-1:0] area_total;
    logic [AREA_W-1:0] area_buried;
    logic              result_load;
    logic              out_free;

    // Result stage.
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [AREA_W-1:0]  out_total_reg;
    logic [AREA_W-1:0]  out_buried_reg;
    logic [CMP_W-1:0]   cnt_ext;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_sel_t'(paddr[2]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_radius_reg <= '0;
            spot_count_reg <= SPOT_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_OWN_RADIUS: own_radius_reg <= pwdata[RADIUS_W-1:0];
                REG_SPOT_COUNT: spot_count_reg <= pwdata[SPOT_COUNT_W-1:0];
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (reg_sel)
            REG_OWN_RADIUS: prdata = PDATA_W'(own_radius_reg);
            REG_SPOT_COUNT: prdata = PDATA_W'(spot_count_reg);
        endcase
    end

    // Live spot count: zero acts as one, large values stop at the store size.
    assign sc_ext = CMP_W'(spot_count_reg);
    always_comb
    begin
        if (sc_ext == '0)
        begin
            live = CNT_W'(1);
        end
        else if (sc_ext > CMP_W'(MAX_SPOTS))
        begin
            live = CNT_W'(MAX_SPOTS);
        end
        else
        begin
            live = sc_ext[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign req_idx    = IDXC_W'(req.spot_index);
    assign req_idx_ok = req_idx < IDXC_W'(MAX_SPOTS);
    assign k_next     = k_reg + 1'b1;
    assign last       = k_next >= limit_reg;
    assign out_free   = !out_valid_reg || rsp.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (k_reg == CNT_W'(MAX_SPOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (op_t'(req.operation)) inside
                        OP_LOAD:                state_next = req_idx_ok ? ST_LOAD_RD : ST_AREA;
                        OP_TEST, OP_TRANSLATE:  state_next = ST_PREP;
                        OP_REPORT:              state_next = ST_AREA;
                    endcase
                end
            end
            ST_LOAD_RD: state_next = ST_LOAD_WR;
            ST_LOAD_WR: state_next = ST_AREA;
            ST_PREP:    state_next = ST_AXIS_X;
            ST_AXIS_X:  state_next = ST_AXIS_Y;
            ST_AXIS_Y:  state_next = ST_AXIS_Z;
            ST_AXIS_Z:  state_next = ST_WRITE;
            ST_WRITE:   state_next = last ? ST_AREA : ST_AXIS_X;
            ST_AREA:    state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (area_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        mem_wr_en          = 1'b0;
        mem_wr_addr        = k_reg[IDX_W-1:0];
        mem_wr_data        = '0;
        mem_rd_en          = 1'b0;
        mem_rd_addr        = k_reg[IDX_W-1:0];
        unit_ctrl.start    = 1'b0;
        unit_ctrl.step     = 1'b0;
        unit_ctrl.subtract = (op_reg == OP_TEST);
        unit_ctrl.axis     = AXIS_X;
        area_start         = 1'b0;
        area_ack           = 1'b0;
        result_load        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en = 1'b1;
            end
            ST_LOAD_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg[IDX_W-1:0];
            end
            ST_LOAD_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg[IDX_W-1:0];
                mem_wr_data = {pos_z_reg, pos_y_reg, pos_x_reg, 1'b0};
            end
            ST_PREP:
            begin
                mem_rd_en       = 1'b1;
                unit_ctrl.start = 1'b1;
            end
            ST_AXIS_X:
            begin
                unit_ctrl.step = 1'b1;
                unit_ctrl.axis = AXIS_X;
            end
            ST_AXIS_Y:
            begin
                unit_ctrl.step = 1'b1;
                unit_ctrl.axis = AXIS_Y;
            end
            ST_AXIS_Z:
            begin
                unit_ctrl.step = 1'b1;
                unit_ctrl.axis = AXIS_Z;
            end
            ST_WRITE:
            begin
                mem_wr_en   = 1'b1;
                mem_rd_en   = !last;
                mem_rd_addr = k_next[IDX_W-1:0];
                if (op_reg == OP_TEST)
                begin
                    mem_wr_data = {mem_rd_data[WORD_W-1:1], mem_rd_data[0] | unit_near};
                end
                else if (k_reg < live_reg)
                begin
                    mem_wr_data = {unit_coords, 1'b0};
                end
                else
                begin
                    mem_wr_data = {mem_rd_data[WORD_W-1:1], 1'b0};
                end
            end
            ST_AREA:
            begin
                area_start = 1'b1;
            end
            ST_WAIT:
            begin
                area_ack    = area_done && out_free;
                result_load = area_done && out_free;
            end
            default:
            begin
            end
        endcase
    end

    // State register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    k_reg <= k_next;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        k_reg <= '0;
                    end
                end
                ST_LOAD_WR:
                begin
                    if (mem_rd_data[0])
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_WRITE:
                begin
                    k_reg <= k_next;
                    if (op_reg == OP_TEST)
                    begin
                        if (!mem_rd_data[0] && unit_near)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    else if (last)
                    begin
                        cnt_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Item payload, taken on a transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(req.operation);
            idx_reg    <= req_idx;
            pos_x_reg  <= req.pos_x;
            pos_y_reg  <= req.pos_y;
            pos_z_reg  <= req.pos_z;
            radius_reg <= req.other_radius;
            live_reg   <= live;
            limit_reg  <= (op_t'(req.operation) == OP_TEST) ? live : CNT_W'(MAX_SPOTS);
        end
    end

    // ------------------------------------------------------------------
    // Spot store, shared spot unit and area unit
    // ------------------------------------------------------------------
    ssba_spot_mem #(
        .DEPTH (MAX_SPOTS),
        .WIDTH (WORD_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ssba_spot_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_unit (
        .clk        (clk),
        .ctrl       (unit_ctrl),
        .radius     (radius_reg),
        .spot_word  (mem_rd_data),
        .pos_x      (pos_x_reg),
        .pos_y      (pos_y_reg),
        .pos_z      (pos_z_reg),
        .near       (unit_near),
        .new_coords (unit_coords)
    );

    ssba_area_unit #(
        .MAX_SPOTS (MAX_SPOTS)
    ) u_area (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (area_start),
        .ack         (area_ack),
        .own_radius  (own_radius_reg),
        .count       (cnt_reg),
        .live        (live_reg),
        .done        (area_done),
        .total_area  (area_total),
        .buried_area (area_buried)
    );

    // ------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------
    assign cnt_ext = CMP_W'(cnt_reg);

    // Valid flag of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; the count saturates to the field width.
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_count_reg  <= (cnt_ext > CMP_W'(COUNT_MAX)) ? COUNT_MAX
                                                            : cnt_ext[COUNT_W-1:0];
            out_total_reg  <= area_total;
            out_buried_reg <= area_buried;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.buried_count = out_count_reg;
    assign rsp.total_area   = out_total_reg;
    assign rsp.buried_area  = out_buried_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SSBA_ASSERT_NOW(a_count_bound, 1'b1, cnt_reg <= CNT_W'(MAX_SPOTS))
    `SSBA_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready)
    `SSBA_ASSERT_NOW(a_translate_clears, state_reg == ST_AREA && op_reg == OP_TRANSLATE, cnt_reg == '0)
    `SSBA_ASSERT_NOW(a_buried_in_total, area_done, area_buried <= area_total)

endmodule

// ===== tb/ssba_burial_checker.sv =====
// ----------------------------------------------------------------------------
// ssba_burial_checker
// Watches the configuration port and both channels of the sphere spot burial
// area block. It keeps its own copy of the spots, flags and registers, works
// out the result of every accepted operation and compares each result
// transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ssba_burial_checker
    import ssba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    ssba_req_if                req_mon,
    ssba_rsp_if                rsp_mon,
    output int                 mismatches,
    output int                 pending
);

    localparam int     SPOTS    = MAX_SPOTS_DEF;
    localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS_DEF - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;

    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [AREA_W-1:0]  tot;
        logic [AREA_W-1:0]  bur;
    } area_result_t;

    longint         spot_pos [SPOTS][3];
    bit             spot_buried [SPOTS];
    int unsigned    buried_num;
    logic [15:0]    radius_reg;
    logic [10:0]    count_reg;
    area_result_t   area_q [$];

    // Applies one operation to the shadow state and returns the area result.
    function automatic area_result_t apply_op(op_t op, logic [INDEX_W-1:0] idx,
                                              longint px, longint py, longint pz,
                                              logic [RADIUS_W-1:0] orad);
        longint              p [3];
        longint              d;
        longint              d2;
        longint              r2;
        longint              v;
        bit                  near;
        int unsigned         n;
        longint unsigned     tot;
        longint unsigned     bur;
        area_result_t        res;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        n = (count_reg == 0) ? 1 : (count_reg > SPOTS) ? SPOTS : count_reg;
        case (op)
            OP_LOAD:
            begin
                for (int c = 0; c < 3; c++)
                    spot_pos[idx][c] = p[c];
                if (spot_buried[idx])
                begin
                    spot_buried[idx] = 1'b0;
                    buried_num--;
                end
            end
            OP_TEST:
            begin
                r2 = longint'(orad) * longint'(orad);
                for (int k = 0; k < n; k++)
                begin
                    if (!spot_buried[k])
                    begin
                        near = 1'b1;
                        d2 = 0;
                        for (int c = 0; c < 3; c++)
                        begin
                            d = spot_pos[k][c] - p[c];
                            if (d < 0)
                                d = -d;
                            if (d > MAG_LIMIT)
                                near = 1'b0;
                            else
                                d2 += d * d;
                        end
                        if (near && d2 < r2)
                        begin
                            spot_buried[k] = 1'b1;
                            buried_num++;
                        end
                    end
                end
            end
            OP_TRANSLATE:
            begin
                for (int k = 0; k < n; k++)
                    for (int c = 0; c < 3; c++)
                    begin
                        v = spot_pos[k][c] + p[c];
                        spot_pos[k][c] = (v > COORD_HI) ? COORD_HI :
                                         (v < COORD_LO) ? COORD_LO : v;
                    end
                for (int k = 0; k < SPOTS; k++)
                    spot_buried[k] = 1'b0;
                buried_num = 0;
            end
            default:
            begin
            end
        endcase
        // Area: 4*pi*r^2 with 4*pi in Q24, rounded, then the buried share.
        tot = (longint'(radius_reg) * longint'(radius_reg) * FOUR_PI_Q24
               + (64'd1 << 31)) >> 32;
        if (tot > AREA_MAX)
            tot = AREA_MAX;
        bur = (longint'(buried_num) * tot) / n;
        if (bur > tot)
            bur = tot;
        res.cnt = (buried_num > COUNT_MAX) ? COUNT_MAX : buried_num[COUNT_W-1:0];
        res.tot = tot[AREA_W-1:0];
        res.bur = bur[AREA_W-1:0];
        return res;
    endfunction

    // Checks result transfers first, then predicts accepted operations.
    always @(posedge clk or negedge rst_n)
    begin
        area_result_t exp_res;
        area_result_t act_res;
        if (!rst_n)
        begin
            for (int k = 0; k < SPOTS; k++)
            begin
                spot_buried[k] = 1'b0;
                for (int c = 0; c < 3; c++)
                    spot_pos[k][c] = 0;
            end
            buried_num = 0;
            radius_reg = '0;
            count_reg  = SPOT_COUNT_RESET;
            area_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (reg_sel_t'(paddr[2]) == REG_OWN_RADIUS)
                    radius_reg = pwdata[15:0];
                else
                    count_reg = pwdata[10:0];
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                act_res.cnt = rsp_mon.buried_count;
                act_res.tot = rsp_mon.total_area;
                act_res.bur = rsp_mon.buried_area;
                if (area_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Unexpected result transfer: count %0d total %0d buried %0d",
                                 act_res.cnt, act_res.tot, act_res.bur);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_res = area_q.pop_front();
                    if (exp_res != act_res)
                    begin
                        if (mismatches < 10)
                            $display("Mismatch (exp/act): count %0d/%0d total %0d/%0d bur %0d/%0d",
                                     exp_res.cnt, act_res.cnt, exp_res.tot, act_res.tot,
                                     exp_res.bur, act_res.bur);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                area_q.push_back(apply_op(op_t'(req_mon.operation), req_mon.spot_index,
                                          longint'($signed(req_mon.pos_x)),
                                          longint'($signed(req_mon.pos_y)),
                                          longint'($signed(req_mon.pos_z)),
                                          req_mon.other_radius));
            pending <= area_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sphere spot burial area block: a directed
// opening, then random phases over several register settings, with random
// idling on both channels, and a final phase on a larger spot set.
// ----------------------------------------------------------------------------
module tb;
    import ssba_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 mismatches;
    int                 pending;
    int                 cycles = 0;
    int                 stall_left;
    bit                 idle_on;
    bit                 written [MAX_SPOTS_DEF];

    ssba_req_if #(.COORD_BITS(COORD_BITS_DEF)) req ();
    ssba_rsp_if rsp ();

    sphere_spot_burial_area i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req),
        .rsp     (rsp)
    );

    ssba_burial_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .req_mon    (req),
        .rsp_mon    (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Clock.
    always #2 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: ready, with random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end
        else
            rsp.ready <= 1'b1;
    end

    function automatic logic signed [19:0] near_coord(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[19:0];
    endfunction

    function automatic logic signed [19:0] any_coord();
        logic [31:0] v;
        v = $urandom;
        return v[19:0];
    endfunction

    // One operation transfer, with an optional idle burst in front.
    task automatic send_op(op_t op, logic [INDEX_W-1:0] idx, logic signed [19:0] x,
                           logic signed [19:0] y, logic signed [19:0] z,
                           logic [RADIUS_W-1:0] r);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.operation    <= op;
        req.spot_index   <= idx;
        req.pos_x        <= x;
        req.pos_y        <= y;
        req.pos_z        <= z;
        req.other_radius <= r;
        do
            @(posedge clk);
        while (!req.ready);
        if (op == OP_LOAD)
            written[idx] = 1'b1;
    endtask

    task automatic load_near(int idx);
        send_op(OP_LOAD, idx[INDEX_W-1:0], near_coord(3000), near_coord(3000),
                near_coord(3000), RADIUS_W'($urandom));
    endtask

    // Waits until every predicted result has come back.
    task automatic drain();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic reg_write(reg_sel_t sel, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // New register setting, then every live spot not yet loaded is loaded before any walk.
    task automatic start_phase(logic [15:0] radius, logic [10:0] count);
        int n;
        drain();
        reg_write(REG_OWN_RADIUS, PDATA_W'(radius));
        reg_write(REG_SPOT_COUNT, PDATA_W'(count));
        n = (count == 0) ? 1 : (count > MAX_SPOTS_DEF) ? MAX_SPOTS_DEF : count;
        for (int i = 0; i < n; i++)
            if (!written[i])
                load_near(i);
    endtask

    // Random operation: mostly clustered content, some full-range noise.
    task automatic random_op(int n);
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n - 1)
                                             : $urandom_range(0, MAX_SPOTS_DEF - 1);
            if ($urandom_range(0, 9) == 0)
                send_op(OP_LOAD, idx[INDEX_W-1:0], any_coord(), any_coord(), any_coord(),
                        RADIUS_W'($urandom));
            else
                load_near(idx);
        end
        else if (pick < 75)
        begin
            if ($urandom_range(0, 9) == 0)
                send_op(OP_TEST, INDEX_W'($urandom), any_coord(), any_coord(), any_coord(),
                        RADIUS_W'($urandom));
            else
                send_op(OP_TEST, INDEX_W'($urandom), near_coord(4000), near_coord(4000),
                        near_coord(4000), RADIUS_W'($urandom_range(0, 6000)));
        end
        else if (pick < 80)
        begin
            if ($urandom_range(0, 3) == 0)
                send_op(OP_TRANSLATE, INDEX_W'($urandom), any_coord(), any_coord(),
                        any_coord(), RADIUS_W'($urandom));
            else
                send_op(OP_TRANSLATE, INDEX_W'($urandom), near_coord(500), near_coord(500),
                        near_coord(500), RADIUS_W'($urandom));
        end
        else
            send_op(OP_REPORT, INDEX_W'($urandom), any_coord(), any_coord(), any_coord(),
                    RADIUS_W'($urandom));
    endtask

    // Main sequence.
    initial
    begin
        int n;
        logic [10:0] cnt;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        idle_on = 1'b1;
        req.valid        = 1'b0;
        req.operation    = OP_REPORT;
        req.spot_index   = '0;
        req.pos_x        = '0;
        req.pos_y        = '0;
        req.pos_z        = '0;
        req.other_radius = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening on eight spots.
        start_phase(16'h1234, 11'd8);
        send_op(OP_REPORT, '0, '0, '0, '0, '0);
        send_op(OP_TEST, '0, '0, '0, '0, 16'd0);
        send_op(OP_TEST, '0, '0, '0, '0, 16'hFFFF);
        send_op(OP_LOAD, 10'd3, 20'sd100, -20'sd100, 20'sd7, '0);
        send_op(OP_TEST, '0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 16'hFFFF);
        send_op(OP_TEST, 10'h3FF, 20'sd100, -20'sd100, 20'sd7, 16'd1500);
        send_op(OP_TRANSLATE, '0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, '0);
        send_op(OP_TEST, '0, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 16'd1);
        send_op(OP_TRANSLATE, '0, 20'sh80000, 20'sh80000, 20'sh80000, 16'hFFFF);
        send_op(OP_TEST, '0, 20'sh80000, 20'sh80000, 20'sh80000, 16'hFFFF);
        send_op(OP_LOAD, 10'h3FF, 20'sh80000, 20'sh7FFFF, 20'sh80000, 16'hFFFF);
        send_op(OP_LOAD, 10'd0, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, '0);
        send_op(OP_TEST, 10'h2AA, 20'sh70000, 20'sh80000, 20'sh70000, 16'hFFFF);
        send_op(OP_TEST, 10'h155, 20'sh70000, 20'sh80000, 20'sh7FFFF, 16'hFFFF);
        send_op(OP_REPORT, 10'h3FF, 20'shFFFFF, 20'shFFFFF, 20'shFFFFF, 16'hFFFF);

        // Random phases over several register settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: cnt = 11'd1;
                1: cnt = 11'd0;
                default: cnt = 11'($urandom_range(2, 40));
            endcase
            start_phase((ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF : 16'($urandom), cnt);
            n = (cnt == 0) ? 1 : cnt;
            repeat (100) random_op(n);
        end

        // Larger spot set, no idling on either side.
        idle_on = 1'b0;
        start_phase(16'hFFFF, 11'd64);
        repeat (80) random_op(64);

        drain();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ssba_pkg.sv
hdl/ssba_if.sv
hdl/ssba_spot_mem.sv
hdl/ssba_spot_unit.sv
hdl/ssba_area_unit.sv
hdl/sphere_spot_burial_area.sv
tb/ssba_burial_checker.sv
tb/tb.sv
